@@ rtl/bl_pkg.sv @@
// ----------------------------------------------------------------------------
// bl_pkg
// Types and constants shared by the line generator's front end, back end and
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bl_pkg;

   localparam int COORD_BITS = 12;
   localparam int DEC_BITS   = COORD_BITS + 2;
   localparam int INC_BITS   = COORD_BITS + 1;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd3;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic      operation;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } bl_req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      logic      pixel_valid;
      logic      last_pixel;
   } bl_rsp_type;

   // classified item handed from the front end to the back end
   typedef struct packed {
      logic                       operation;
      logic                       steep;
      logic                       single;
      logic [1:0]                 direction;
      coord_type                  major_start;
      coord_type                  minor_start;
      coord_type                  major_end;
      logic signed [DEC_BITS-1:0] decision;
      logic [INC_BITS-1:0]        inc_straight;
      logic signed [DEC_BITS-1:0] inc_diagonal;
   } bl_cmd_type;

endpackage

`default_nettype wire

@@ rtl/bl_fifo.sv @@
// ----------------------------------------------------------------------------
// bl_fifo
// Small register queue with push/full and pop/empty; DEPTH a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module bl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             pop,
   output logic                  empty,
   output logic      [WIDTH-1:0] rd_data
);

   localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/bl_front.sv @@
// ----------------------------------------------------------------------------
// bl_front
// Classifies an item: for a start, picks the major axis, orders the
// endpoints and works out the decision term and its increments.
// ----------------------------------------------------------------------------
`default_nettype none

module bl_front (
   input  wire bl_pkg::bl_req_type req,
   output bl_pkg::bl_cmd_type      cmd
);

   import bl_pkg::*;

   coord_type           adx, ady, dmaj, dmin;
   coord_type           ma0, mi0, ma1;
   logic                x_desc, y_desc, steep, swap, minor_up;
   logic [DEC_BITS-1:0] dmin2, dmaj1, dmaj2;

   always_comb begin
      x_desc   = req.start_x > req.end_x;
      y_desc   = req.start_y > req.end_y;
      adx      = x_desc ? req.start_x - req.end_x : req.end_x - req.start_x;
      ady      = y_desc ? req.start_y - req.end_y : req.end_y - req.start_y;
      steep    = ady > adx;
      swap     = steep ? y_desc : x_desc;
      dmaj     = steep ? ady : adx;
      dmin     = steep ? adx : ady;
      minor_up = steep ? ~(swap ^ x_desc) : ~(swap ^ y_desc);
      if (steep) begin
         ma0 = swap ? req.end_y   : req.start_y;
         ma1 = swap ? req.start_y : req.end_y;
         mi0 = swap ? req.end_x   : req.start_x;
      end else begin
         ma0 = swap ? req.end_x   : req.start_x;
         ma1 = swap ? req.start_x : req.end_x;
         mi0 = swap ? req.end_y   : req.start_y;
      end
      dmin2 = {1'b0, dmin, 1'b0};
      dmaj1 = {2'b00, dmaj};
      dmaj2 = {1'b0, dmaj, 1'b0};

      cmd              = '0;
      cmd.operation    = req.operation;
      cmd.steep        = steep;
      cmd.single       = (ma0 == ma1);
      cmd.direction    = (dmin == '0) ? DIR_NONE : (minor_up ? DIR_UP : DIR_DOWN);
      cmd.major_start  = ma0;
      cmd.minor_start  = mi0;
      cmd.major_end    = ma1;
      cmd.decision     = $signed(dmin2 - dmaj1);
      cmd.inc_straight = {dmin, 1'b0};
      cmd.inc_diagonal = $signed(dmin2 - dmaj2);
   end

endmodule

`default_nettype wire

@@ rtl/bl_back.sv @@
// ----------------------------------------------------------------------------
// bl_back
// Holds the active line: loads it on a start item and steps it one pixel per step item.
// ----------------------------------------------------------------------------
`default_nettype none

module bl_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bl_pkg::bl_cmd_type cmd,
   input  wire logic               cmd_empty,
   output logic                    cmd_pop,
   output bl_pkg::bl_rsp_type      rsp,
   output logic                    rsp_push,
   input  wire logic               rsp_full
);

   import bl_pkg::*;

   logic                       active_ff, active_in;
   logic                       steep_ff, steep_in;
   coord_type                  major_ff, major_in;
   coord_type                  minor_ff, minor_in;
   coord_type                  major_end_ff, major_end_in;
   logic [1:0]                 dir_ff, dir_in;
   logic signed [DEC_BITS-1:0] decision_ff, decision_in;
   logic [INC_BITS-1:0]        inc_s_ff, inc_s_in;
   logic signed [DEC_BITS-1:0] inc_d_ff, inc_d_in;
   logic                       fin;

   assign cmd_pop  = !cmd_empty && !rsp_full;
   assign rsp_push = cmd_pop;

   always_comb begin
      active_in    = active_ff;
      steep_in     = steep_ff;
      major_in     = major_ff;
      minor_in     = minor_ff;
      major_end_in = major_end_ff;
      dir_in       = dir_ff;
      decision_in  = decision_ff;
      inc_s_in     = inc_s_ff;
      inc_d_in     = inc_d_ff;
      fin          = 1'b0;
      rsp          = '0;
      if (cmd_pop) begin
         if (cmd.operation == OP_START) begin
            steep_in     = cmd.steep;
            major_in     = cmd.major_start;
            minor_in     = cmd.minor_start;
            major_end_in = cmd.major_end;
            dir_in       = cmd.direction;
            decision_in  = cmd.decision;
            inc_s_in     = cmd.inc_straight;
            inc_d_in     = cmd.inc_diagonal;
            fin          = cmd.single;
         end else if (active_ff) begin
            major_in = major_ff + 1'b1;
            if (decision_ff < 0) begin
               decision_in = decision_ff + $signed({1'b0, inc_s_ff});
            end else begin
               decision_in = decision_ff + inc_d_ff;
               if (dir_ff == DIR_UP) begin
                  minor_in = minor_ff + 1'b1;
               end else if (dir_ff == DIR_DOWN) begin
                  minor_in = minor_ff - 1'b1;
               end
            end
            fin = (major_in == major_end_ff);
         end
         if (cmd.operation == OP_START || active_ff) begin
            active_in       = !fin;
            rsp.pixel_x     = steep_in ? minor_in : major_in;
            rsp.pixel_y     = steep_in ? major_in : minor_in;
            rsp.pixel_valid = 1'b1;
            rsp.last_pixel  = fin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      steep_ff     <= steep_in;
      major_ff     <= major_in;
      minor_ff     <= minor_in;
      major_end_ff <= major_end_in;
      dir_ff       <= dir_in;
      decision_ff  <= decision_in;
      inc_s_ff     <= inc_s_in;
      inc_d_ff     <= inc_d_in;
   end

endmodule

`default_nettype wire

@@ rtl/bresenham_line_generator.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_generator
// Integer line rasteriser, all octants, endpoint included.
//
// Input queue: push, full, req_item. A start item carries both endpoints and
// returns the first pixel; each step item returns the next pixel, with
// last_pixel on the final one. A step with no line active returns an item
// with pixel_valid low.
// Result queue: empty, pop, rsp_item. The oldest result sits on rsp_item
// while empty is low.
// An accepted item is written into the command queue; its result goes into
// the result queue when the back end pops it from there.
// Throughput: one item per cycle while the result queue is not full; the
// back end's decision update is combinational.
// A two-entry queue sits between front end and back end and another on the
// result side; if pop is held low the result queue fills, the back end
// stops, the command queue fills and full rises.
// Reset (synchronous) empties both queues and drops any active line.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_generator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire bl_pkg::bl_req_type req_item,
   output logic                    empty,
   input  wire logic               pop,
   output bl_pkg::bl_rsp_type      rsp_item
);

   import bl_pkg::*;

   localparam int CMD_W = $bits(bl_cmd_type);
   localparam int RSP_W = $bits(bl_rsp_type);

   bl_cmd_type       cmd_wr, cmd_rd;
   logic [CMD_W-1:0] cmd_rd_bits;
   logic             cmd_empty, cmd_pop;
   bl_rsp_type       rsp_wr;
   logic [RSP_W-1:0] rsp_rd_bits;
   logic             rsp_push, rsp_full;

   bl_front u_front (
      .req (req_item),
      .cmd (cmd_wr)
   );

   bl_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .wr_data (CMD_W'(cmd_wr)),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_data (cmd_rd_bits)
   );

   assign cmd_rd = bl_cmd_type'(cmd_rd_bits);

   bl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_rd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_wr),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   bl_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .full    (rsp_full),
      .wr_data (RSP_W'(rsp_wr)),
      .pop     (pop),
      .empty   (empty),
      .rd_data (rsp_rd_bits)
   );

   assign rsp_item = bl_rsp_type'(rsp_rd_bits);

endmodule

`default_nettype wire

@@ bench/line_pixel_checker.sv @@
// ----------------------------------------------------------------------------
// line_pixel_checker
// Watches both queues of the line generator. It keeps its own copy of the line
// state and works out the pixel for every accepted input item. Each result
// popped from the block is compared with the oldest pixel still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module line_pixel_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire logic               full,
   input  wire bl_pkg::bl_req_type req_item,
   input  wire logic               empty,
   input  wire logic               pop,
   input  wire bl_pkg::bl_rsp_type rsp_item,
   output int                      failures,
   output int                      outstanding
);

   import bl_pkg::*;

   localparam int DECISION_BITS = COORD_BITS + 3;

   bl_rsp_type expected_pixels[$];
   int fail_count = 0;
   int pending_count = 0;

   logic                            line_active = 1'b0;
   logic                            line_steep = 1'b0;
   coord_type                       major_pos = '0;
   coord_type                       minor_pos = '0;
   coord_type                       major_stop = '0;
   logic [1:0]                      minor_step = DIR_NONE;
   logic signed [DECISION_BITS-1:0] decision = '0;
   logic [DECISION_BITS-2:0]        straight_inc = '0;
   logic signed [DECISION_BITS-1:0] diagonal_inc = '0;

   assign failures = fail_count;
   assign outstanding = pending_count;

   function automatic bl_rsp_type trace_next_pixel(bl_req_type item);
      int sx, sy, ex, ey, adx, ady, ma0, mi0, ma1, mi1, swap, dmaj, dmin;
      bl_rsp_type pixel;
      pixel = '0;
      if (item.operation == OP_START) begin
         sx = int'(item.start_x);
         sy = int'(item.start_y);
         ex = int'(item.end_x);
         ey = int'(item.end_y);
         adx = ex > sx ? ex - sx : sx - ex;
         ady = ey > sy ? ey - sy : sy - ey;
         line_steep = ady > adx;
         if (line_steep) begin
            ma0 = sy; mi0 = sx; ma1 = ey; mi1 = ex;
         end else begin
            ma0 = sx; mi0 = sy; ma1 = ex; mi1 = ey;
         end
         if (ma0 > ma1) begin
            swap = ma0; ma0 = ma1; ma1 = swap;
            swap = mi0; mi0 = mi1; mi1 = swap;
         end
         dmaj = ma1 - ma0;
         dmin = mi1 - mi0;
         if (dmin > 0) begin
            minor_step = DIR_UP;
         end else if (dmin < 0) begin
            minor_step = DIR_DOWN;
            dmin = -dmin;
         end else begin
            minor_step = DIR_NONE;
         end
         major_pos = coord_type'(ma0);
         minor_pos = coord_type'(mi0);
         major_stop = coord_type'(ma1);
         straight_inc = (DECISION_BITS-1)'(2 * dmin);
         diagonal_inc = DECISION_BITS'(2 * (dmin - dmaj));
         decision = DECISION_BITS'(2 * dmin - dmaj);
         line_active = 1'b1;
      end else if (!line_active) begin
         return pixel;
      end else begin
         major_pos = major_pos + 1'b1;
         if (decision < 0) begin
            decision = decision + $signed({1'b0, straight_inc});
         end else begin
            decision = decision + diagonal_inc;
            if (minor_step == DIR_UP) begin
               minor_pos = minor_pos + 1'b1;
            end else if (minor_step == DIR_DOWN) begin
               minor_pos = minor_pos - 1'b1;
            end
         end
      end
      pixel.pixel_x = line_steep ? minor_pos : major_pos;
      pixel.pixel_y = line_steep ? major_pos : minor_pos;
      pixel.pixel_valid = 1'b1;
      pixel.last_pixel = (major_pos == major_stop);
      if (pixel.last_pixel) begin
         line_active = 1'b0;
      end
      return pixel;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      bl_rsp_type want;
      if (reset) begin
         expected_pixels.delete();
         line_active = 1'b0;
         line_steep = 1'b0;
         major_pos = '0;
         minor_pos = '0;
         major_stop = '0;
         minor_step = DIR_NONE;
         decision = '0;
         straight_inc = '0;
         diagonal_inc = '0;
      end else begin
         if (pop && !empty) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: item with nothing expected, got x=%0d y=%0d valid=%0b last=%0b",
                        $time, rsp_item.pixel_x, rsp_item.pixel_y,
                        rsp_item.pixel_valid, rsp_item.last_pixel);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("pixel_x", int'(want.pixel_x), int'(rsp_item.pixel_x));
               check_field("pixel_y", int'(want.pixel_y), int'(rsp_item.pixel_y));
               check_field("pixel_valid", int'(want.pixel_valid),
                           int'(rsp_item.pixel_valid));
               check_field("last_pixel", int'(want.last_pixel),
                           int'(rsp_item.last_pixel));
            end
         end
         if (push && !full) begin
            expected_pixels.push_back(trace_next_pixel(req_item));
         end
      end
      pending_count <= expected_pixels.size();
   end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives line start and step items into the line generator with random gaps
// on both queues: a directed pass over the corner cases, then random lines,
// aborted lines and stray steps. The checker beside the block does the
// comparison; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   import bl_pkg::*;

   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int STALL_LIMIT = 4000;
   localparam int ITEM_TARGET = 625;

   logic       clock;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       pop = 1'b0;
   bl_req_type req_item = '0;
   logic       full;
   logic       empty;
   bl_rsp_type rsp_item;
   int         failures;
   int         outstanding;

   int         sent_items = 0;
   bit         gapless = 1'b0;

   bresenham_line_generator dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   line_pixel_checker pixel_check (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_item    (req_item),
      .empty       (empty),
      .pop         (pop),
      .rsp_item    (rsp_item),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int pick_coord();
      if ($urandom_range(0, 6) == 0) return $urandom_range(0, 1) ? COORD_MAX : 0;
      return $urandom_range(0, COORD_MAX);
   endfunction

   function automatic int pick_delta();
      int r, d;
      r = $urandom_range(0, 99);
      if (r < 70) d = $urandom_range(0, 12);
      else if (r < 96) d = $urandom_range(13, 120);
      else d = $urandom_range(121, 250);
      return $urandom_range(0, 1) ? d : -d;
   endfunction

   function automatic int clamp_coord(int c);
      if (c < 0) return 0;
      if (c > COORD_MAX) return COORD_MAX;
      return c;
   endfunction

   task automatic send_item(input logic op, input int sx, input int sy,
                            input int ex, input int ey);
      int n;
      n = gapless ? 0 : gap_len();
      if (n > 0) begin
         push <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_item <= '{operation: op, start_x: coord_type'(sx), start_y: coord_type'(sy),
                    end_x: coord_type'(ex), end_y: coord_type'(ey)};
      push <= 1'b1;
      do @(posedge clock); while (full);
      sent_items++;
   endtask

   task automatic send_step();
      send_item(OP_STEP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
   endtask

   // start plus the steps that reach the endpoint; cut stops short, extra runs past it
   task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                            input int extra, input bit cut);
      int dx, dy, steps;
      dx = ex > sx ? ex - sx : sx - ex;
      dy = ey > sy ? ey - sy : sy - ey;
      steps = dx > dy ? dx : dy;
      if (cut && steps > 0) steps = $urandom_range(0, steps > 20 ? 20 : steps - 1);
      send_item(OP_START, sx, sy, ex, ey);
      repeat (steps + extra) send_step();
   endtask

   task automatic drain_pixels();
      push <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("bresenham_line_generator verification failed");
      $finish;
   end

   initial begin
      int n;
      repeat (8) @(posedge clock);
      forever begin
         n = gap_len();
         if (n > 0) begin
            pop <= 1'b0;
            repeat (n) @(posedge clock);
         end
         pop <= 1'b1;
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 20))
            @(posedge clock);
      end
   end

   initial begin
      int kind, sx, sy, ex, ey;
      bit paused;
      paused = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_step();
      draw_line(0, 0, 0, 0, 1, 1'b0);
      draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 1'b0);
      send_item(OP_START, 0, 0, COORD_MAX, COORD_MAX);
      send_step();
      send_item(OP_START, COORD_MAX, 0, 0, COORD_MAX);
      send_step();
      draw_line(3, 5, 0, 4, 0, 1'b0);
      draw_line(2, 1, 3, 6, 0, 1'b0);
      draw_line(COORD_MAX, 10, COORD_MAX - 3, 10, 1, 1'b0);
      draw_line(10, COORD_MAX, 12, COORD_MAX - 5, 0, 1'b0);
      drain_pixels();

      while (sent_items < ITEM_TARGET) begin
         if (!paused && sent_items > ITEM_TARGET / 2) begin
            drain_pixels();
            paused = 1'b1;
         end
         kind = $urandom_range(0, 99);
         gapless = ($urandom_range(0, 4) == 0);
         sx = pick_coord();
         sy = pick_coord();
         ex = clamp_coord(sx + pick_delta());
         ey = clamp_coord(sy + pick_delta());
         if (kind < 75) begin
            draw_line(sx, sy, ex, ey, $urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : 0,
                      1'b0);
         end else if (kind < 85) begin
            draw_line(sx, sy, ex, ey, 0, 1'b1);
         end else if (kind < 93) begin
            draw_line($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), 0, 1'b1);
         end else begin
            repeat ($urandom_range(1, 4)) send_step();
         end
      end

      drain_pixels();
      repeat (8) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("bresenham_line_generator verification clean");
      end else begin
         $display("bresenham_line_generator verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
